// File: sv/wlmd_pkg.sv
// ============================================================================
// wlmd_pkg
// Shared constants, types and register codes of the windowed local maximum
// detector.
// ============================================================================
package wlmd_pkg;

    // window geometry
    localparam int WIN_RADIUS = 2;
    localparam int SPAN       = 2 * WIN_RADIUS + 1;
    localparam int LINES      = 2 * WIN_RADIUS;

    // image limits
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);

    // pixel and result fields
    localparam int HEIGHT_W  = 16;
    localparam int CELL_W    = HEIGHT_W + 1;
    localparam int OUT_ROW_W = 10;
    localparam int OUT_COL_W = 10;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SIZE_W     = 11;
    localparam int SIZE_RESET = 1024;

    // widths wide enough for both the size register and the clamp limit, or for both position fields
    localparam int COLS_XW = (SIZE_W > COL_W + 1) ? SIZE_W : COL_W + 1;
    localparam int ROWS_XW = (SIZE_W > ROW_W + 1) ? SIZE_W : ROW_W + 1;
    localparam int ROW_XW  = (ROW_W > OUT_ROW_W) ? ROW_W : OUT_ROW_W;
    localparam int COL_XW  = (COL_W > OUT_COL_W) ? COL_W : OUT_COL_W;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    // beats that can still be in the front pipeline when one is accepted
    localparam int FRONT_SLOTS = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FLOOR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_MARGIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = CFG_IDX_W'(3);

    // bit HEIGHT_W is the occupied flag, the rest the height
    typedef logic [CELL_W-1:0] cell_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [HEIGHT_W-1:0]  height;
    } peak_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] peak_floor;
        logic [HEIGHT_W-1:0] rise_margin;
        logic [COL_W:0]      cols;
        logic [ROW_W:0]      rows;
    } cfg_t;

    typedef struct packed {
        logic not_empty;
        logic room;
    } q_status_t;

endpackage

// File: sv/wlmd_front.sv
// ============================================================================
// wlmd_front
// Raster position, line store, 2-D window and peak test; pushes one result
// per detected peak into the result queue.
// ============================================================================
module wlmd_front
    import wlmd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [HEIGHT_W-1:0] s_height,
    input  logic                s_occupied,
    input  q_status_t           q_status,
    output logic                push_valid,
    output peak_t               push_data
);

    localparam int LW = LINES * CELL_W;

    logic             s_fire;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             in_range;

    // stage 1: line store read data and pixel
    logic             s1_valid_reg;
    logic             s1_hit_reg;
    logic             s1_byp_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    cell_t            s1_pix_reg;
    logic [LW-1:0]    rd_data_reg;
    logic [LW-1:0]    byp_data_reg;
    logic [LW-1:0]    old_col;
    logic [LW-1:0]    line_wr;
    logic [LW-1:0]    line_mem [MAX_COLS];
    cell_t            column [SPAN];

    // stage 2: window complete, peak test
    cell_t            win_reg [SPAN][SPAN];
    logic             s2_valid_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;
    cell_t            centre;
    logic [HEIGHT_W:0] limit;
    logic             is_peak;
    logic [ROW_XW-1:0] out_row;
    logic [COL_XW-1:0] out_col;

    assign s_ready = q_status.room;
    assign s_fire  = s_valid && s_ready;

    // border and size check for the centre this beat completes
    assign in_range = (row_reg >= ROW_W'(LINES)) && (col_reg >= COL_W'(LINES)) &&
                      ((COL_W+1)'(col_reg) < cfg.cols) &&
                      ((ROW_W+1)'(row_reg) < cfg.rows);

    // raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_fire) begin
            if ((COL_W+1)'(col_reg) + (COL_W+1)'(1) >= cfg.cols) begin
                col_next = '0;
                if ((ROW_W+1)'(row_reg) + (ROW_W+1)'(1) >= cfg.rows) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store: one word per column holding the previous rows
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= line_wr;
        end
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
            s1_pix_reg <= {s_occupied, s_height};
            s1_hit_reg <= in_range;
            // the word being written this cycle is not yet in the read data
            s1_byp_reg <= s1_valid_reg && (s1_col_reg == col_reg);
        end
        if (s1_valid_reg) begin
            byp_data_reg <= line_wr;
        end
    end

    // new window column and shifted line store word
    always_comb begin
        old_col = s1_byp_reg ? byp_data_reg : rd_data_reg;
        line_wr = {s1_pix_reg, old_col[LW-1:CELL_W]};
        for (int k = 0; k < LINES; k++) begin
            column[k] = old_col[k*CELL_W +: CELL_W];
        end
        column[LINES] = s1_pix_reg;
    end

    // window shifts left, new column on the right
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            for (int dr = 0; dr < SPAN; dr++) begin
                for (int dc = 0; dc < SPAN - 1; dc++) begin
                    win_reg[dr][dc] <= win_reg[dr][dc+1];
                end
                win_reg[dr][SPAN-1] <= column[dr];
            end
        end
    end

    // stage 2 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg && s1_hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
        end
    end

    // peak test: occupied centre at or above the floor, no neighbour above centre plus tolerance
    always_comb begin
        centre  = win_reg[WIN_RADIUS][WIN_RADIUS];
        limit   = {1'b0, centre[HEIGHT_W-1:0]} + {1'b0, cfg.rise_margin};
        is_peak = centre[HEIGHT_W] && (centre[HEIGHT_W-1:0] >= cfg.peak_floor);
        for (int dr = 0; dr < SPAN; dr++) begin
            for (int dc = 0; dc < SPAN; dc++) begin
                if (!(dr == WIN_RADIUS && dc == WIN_RADIUS)) begin
                    if ({1'b0, win_reg[dr][dc][HEIGHT_W-1:0]} > limit) begin
                        is_peak = 1'b0;
                    end
                end
            end
        end
    end

    // centre position
    assign out_row = ROW_XW'(s2_row_reg) - ROW_XW'(WIN_RADIUS);
    assign out_col = COL_XW'(s2_col_reg) - COL_XW'(WIN_RADIUS);

    assign push_valid       = s2_valid_reg && is_peak;
    assign push_data.row    = out_row[OUT_ROW_W-1:0];
    assign push_data.col    = out_col[OUT_COL_W-1:0];
    assign push_data.height = centre[HEIGHT_W-1:0];

endmodule

// File: sv/wlmd_queue.sv
// ============================================================================
// wlmd_queue
// Short result queue between the window front and the output stage.
// ============================================================================
module wlmd_queue
    import wlmd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    input  peak_t     push_data,
    input  logic      pop,
    output peak_t     pop_data,
    output q_status_t q_status
);

    peak_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push_valid) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data           = slot_reg[rd_ptr_reg];
    assign q_status.not_empty = (count_reg != '0);
    // room for every beat the front may still push
    assign q_status.room = (count_reg <= (QPTR_W+1)'(QUEUE_DEPTH - FRONT_SLOTS));

endmodule

// File: sv/wlmd_back.sv
// ============================================================================
// wlmd_back
// Output register stage: drains the result queue onto the result channel.
// ============================================================================
module wlmd_back
    import wlmd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_status_t            q_status,
    input  peak_t                pop_data,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_ROW_W-1:0] m_peak_row,
    output logic [OUT_COL_W-1:0] m_peak_col,
    output logic [HEIGHT_W-1:0]  m_peak_height
);

    logic  m_valid_reg;
    peak_t out_reg;

    // load when the register is empty or its beat leaves
    assign pop = q_status.not_empty && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= pop_data;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_peak_row    = out_reg.row;
    assign m_peak_col    = out_reg.col;
    assign m_peak_height = out_reg.height;

endmodule

// File: sv/windowed_local_max_detector.sv
// ============================================================================
// windowed_local_max_detector
// Local maximum detector over a raster height image with a 5x5 window.
// ============================================================================
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_height[15:0], s_occupied
//  m_        out        m_valid/m_ready    m_peak_row, m_peak_col, m_peak_height
//  cfg_      in         cfg_we             cfg_index[1:0], cfg_wdata[15:0]
//
//  One pixel per cycle while s_ready is high; a peak passes the line store read,
//  the window shift and test, the result queue and the output register to m_.
//  The line store is a single-port-read memory, one word per column.
//  Reset is synchronous; the line store and window are not cleared.
//  s_ready drops when the result queue cannot take the beats in flight.
//
module windowed_local_max_detector
    import wlmd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [HEIGHT_W-1:0]   s_height,
    input  logic                  s_occupied,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_ROW_W-1:0]  m_peak_row,
    output logic [OUT_COL_W-1:0]  m_peak_col,
    output logic [HEIGHT_W-1:0]   m_peak_height
);

    logic [HEIGHT_W-1:0] peak_floor_reg;
    logic [HEIGHT_W-1:0] rise_margin_reg;
    logic [SIZE_W-1:0]   image_cols_reg;
    logic [SIZE_W-1:0]   image_rows_reg;
    logic [COLS_XW-1:0]  cols_ext, cols_eff;
    logic [ROWS_XW-1:0]  rows_ext, rows_eff;
    cfg_t                cfg;
    logic                push_valid;
    peak_t               push_data;
    logic                pop;
    peak_t               pop_data;
    q_status_t           q_status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_floor_reg  <= '0;
            rise_margin_reg <= '0;
            image_cols_reg  <= SIZE_W'(SIZE_RESET);
            image_rows_reg  <= SIZE_W'(SIZE_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PEAK_FLOOR: begin
                    peak_floor_reg <= cfg_wdata[HEIGHT_W-1:0];
                end
                CFG_RISE_MARGIN: begin
                    rise_margin_reg <= cfg_wdata[HEIGHT_W-1:0];
                end
                CFG_IMAGE_COLS: begin
                    image_cols_reg <= cfg_wdata[SIZE_W-1:0];
                end
                CFG_IMAGE_ROWS: begin
                    image_rows_reg <= cfg_wdata[SIZE_W-1:0];
                end
            endcase
        end
    end

    // zero size acts as one, oversize as the maximum
    always_comb begin
        cols_ext = COLS_XW'(image_cols_reg);
        rows_ext = ROWS_XW'(image_rows_reg);
        if (cols_ext == '0) begin
            cols_eff = COLS_XW'(1);
        end else if (cols_ext > COLS_XW'(MAX_COLS)) begin
            cols_eff = COLS_XW'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
        if (rows_ext == '0) begin
            rows_eff = ROWS_XW'(1);
        end else if (rows_ext > ROWS_XW'(MAX_ROWS)) begin
            rows_eff = ROWS_XW'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
    end

    assign cfg.peak_floor  = peak_floor_reg;
    assign cfg.rise_margin = rise_margin_reg;
    assign cfg.cols        = cols_eff[COL_W:0];
    assign cfg.rows        = rows_eff[ROW_W:0];

    wlmd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_height   (s_height),
        .s_occupied (s_occupied),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    wlmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .pop_data   (pop_data),
        .q_status   (q_status)
    );

    wlmd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .pop_data      (pop_data),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_peak_row    (m_peak_row),
        .m_peak_col    (m_peak_col),
        .m_peak_height (m_peak_height)
    );

endmodule

// File: sv/wlmd_checker.sv
// ============================================================================
// wlmd_checker
// Port-level checks of the local maximum detector, bound to the top level.
// ============================================================================
module wlmd_checker
    import wlmd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [OUT_ROW_W-1:0]  m_peak_row,
    input logic [OUT_COL_W-1:0]  m_peak_col,
    input logic [HEIGHT_W-1:0]   m_peak_height
);

    localparam int PEND_W = 8;

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              sat_reg;
    logic              s_fire, m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // accepted pixel beats not yet matched by a result beat
    always_comb begin
        pend_next = pend_reg;
        if (s_fire && !m_fire) begin
            pend_next = pend_reg + PEND_W'(1);
        end else if (m_fire && !s_fire && pend_reg != '0) begin
            pend_next = pend_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            sat_reg  <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (pend_reg == '1) begin
                sat_reg <= 1'b1;
            end
        end
    end

    // no result beat out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
            $stable(m_peak_row) && $stable(m_peak_col) && $stable(m_peak_height))
        else $error("stalled result beat changed");

    // a reported centre is never on the border rows or columns
    a_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_peak_row >= OUT_ROW_W'(WIN_RADIUS)) &&
                    (m_peak_col >= OUT_COL_W'(WIN_RADIUS)))
        else $error("peak reported on the image border");

    // every result beat is backed by an earlier pixel beat
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn || sat_reg)
        m_fire |-> pend_reg != '0)
        else $error("more result beats than pixel beats");

endmodule

bind windowed_local_max_detector wlmd_checker u_wlmd_checker (.*);

// File: tb/windowed_local_max_detector_test.sv
`timescale 1ns / 1ps
// ============================================================================
// windowed_local_max_detector_test
// Self-checking bench for the 5x5 local maximum detector: a short directed
// table, then configured image phases with hilly, noisy and near-full-scale
// heights, checked beat by beat against a cycle-free model of the window.
// ============================================================================
module windowed_local_max_detector_test;
    import wlmd_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int HOLD_CYCLES      = 400;
    localparam int WATCHDOG_CYCLES  = 1_000_000;
    localparam int RANDOM_PHASES    = 2;

    // kinds of height content
    typedef enum logic [1:0] {FILL_HILLS, FILL_NOISE, FILL_TOPS} fill_e;

    // one row of the directed table: a register write or a run of equal pixels
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        logic [HEIGHT_W-1:0]  h;
        logic                 occ;
        int                   reps;
        bit                   hit;
        peak_t                pk;
    } dir_step_t;

    // one image phase: register values and how many pixels to stream
    typedef struct {
        logic [CFG_DATA_W-1:0] min_h;
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] cols;
        logic [CFG_DATA_W-1:0] rows;
        int                    frames;
        int                    n_pix;
        fill_e                 fill;
        bit                    stall;
    } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [HEIGHT_W-1:0]   s_height = '0;
    logic                  s_occupied = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_ROW_W-1:0]  m_peak_row;
    logic [OUT_COL_W-1:0]  m_peak_col;
    logic [HEIGHT_W-1:0]   m_peak_height;

    windowed_local_max_detector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_height      (s_height),
        .s_occupied    (s_occupied),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_peak_row    (m_peak_row),
        .m_peak_col    (m_peak_col),
        .m_peak_height (m_peak_height)
    );

    always #CLK_HALF aclk = ~aclk;

    // software copy of the detector state
    cfg_t        sw_cfg = '{peak_floor: '0, rise_margin: '0,
                            cols: (COL_W+1)'(SIZE_RESET),
                            rows: (ROW_W+1)'(SIZE_RESET)};
    cell_t       line_mem [LINES][MAX_COLS] = '{default: '0};
    cell_t       win_cells [SPAN][SPAN] = '{default: '0};
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;

    peak_t       peaks_due [$];
    int          mismatches = 0;
    int unsigned burst_left = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned rx_cycle = 0;

    // directed table: zero sizes, then one 5x5 frame with a full-scale centre
    dir_step_t dir_steps [12] = '{
        '{1'b1, CFG_IMAGE_COLS,  16'h0000, 16'h0000, 1'b0, 0,  1'b0, '0},
        '{1'b1, CFG_IMAGE_ROWS,  16'h0000, 16'h0000, 1'b0, 0,  1'b0, '0},
        '{1'b0, CFG_PEAK_FLOOR,  16'h0000, 16'hFFFF, 1'b1, 2,  1'b0, '0},
        '{1'b1, CFG_IMAGE_COLS,  16'd5,    16'h0000, 1'b0, 0,  1'b0, '0},
        '{1'b1, CFG_IMAGE_ROWS,  16'd5,    16'h0000, 1'b0, 0,  1'b0, '0},
        '{1'b1, CFG_PEAK_FLOOR,  16'hFFFF, 16'h0000, 1'b0, 0,  1'b0, '0},
        '{1'b1, CFG_RISE_MARGIN, 16'h0000, 16'h0000, 1'b0, 0,  1'b0, '0},
        '{1'b0, CFG_PEAK_FLOOR,  16'h0000, 16'h0000, 1'b0, 12, 1'b0, '0},
        '{1'b0, CFG_PEAK_FLOOR,  16'h0000, 16'hFFFF, 1'b1, 1,  1'b0, '0},
        '{1'b0, CFG_PEAK_FLOOR,  16'h0000, 16'hFFFF, 1'b0, 1,  1'b0, '0},
        '{1'b0, CFG_PEAK_FLOOR,  16'h0000, 16'hFFFE, 1'b1, 10, 1'b0, '0},
        '{1'b0, CFG_PEAK_FLOOR,  16'h0000, 16'h0000, 1'b1, 1,  1'b1,
          '{10'd2, 10'd2, 16'hFFFF}}
    };

    // fixed phases: dense peaks under a long hold, mid-frame size changes,
    // oversize and masked size writes, a partial row at the widest image
    phase_t fixed_phases [10] = '{
        '{16'h0000, 16'h0000, 16'd8,    16'd6,    1, 0,  FILL_HILLS, 1'b0},
        '{16'h0000, 16'hFFFF, 16'd12,   16'd6,    2, 0,  FILL_HILLS, 1'b1},
        '{16'hFFFF, 16'h0000, 16'd6,    16'd7,    1, 0,  FILL_TOPS,  1'b0},
        '{16'h0100, 16'h0040, 16'd16,   16'd6,    1, 0,  FILL_NOISE, 1'b0},
        '{16'h0000, 16'h0080, 16'd10,   16'h07FF, 0, 75, FILL_HILLS, 1'b0},
        '{16'h0000, 16'h0080, 16'd4,    16'd3,    1, 0,  FILL_HILLS, 1'b0},
        '{16'h0000, 16'h0020, 16'd10,   16'h0400, 0, 70, FILL_HILLS, 1'b0},
        '{16'h0000, 16'h0020, 16'd8,    16'd10,   1, 0,  FILL_HILLS, 1'b0},
        '{16'h0000, 16'h0100, 16'h07FF, 16'd5,    0, 30, FILL_HILLS, 1'b0},
        '{16'h0000, 16'h0010, 16'hF805, 16'd5,    2, 0,  FILL_HILLS, 1'b0}
    };

    function automatic int unsigned size_limit(input logic [SIZE_W-1:0] v,
                                               input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return 32'(v);
    endfunction

    // one pixel through the window: shift line store and window, test centre
    function automatic void scan_pixel(input logic [HEIGHT_W-1:0] h, input logic occ,
                                       output bit hit, output peak_t pk);
        int unsigned ncols;
        int unsigned nrows;
        int unsigned c;
        cell_t       fresh [SPAN];
        cell_t       centre;
        logic [HEIGHT_W:0] limit;
        ncols = size_limit(sw_cfg.cols, MAX_COLS);
        nrows = size_limit(sw_cfg.rows, MAX_ROWS);
        c = col_pos;
        hit = 1'b0;
        pk = '0;

        // new window column: stored lines on top, this beat at the bottom
        for (int k = 0; k < LINES; k++) fresh[k] = line_mem[k][c];
        fresh[LINES] = {occ, h};
        for (int k = 0; k < LINES - 1; k++) line_mem[k][c] = line_mem[k + 1][c];
        line_mem[LINES - 1][c] = {occ, h};
        for (int i = 0; i < SPAN; i++) begin
            for (int j = 0; j < SPAN - 1; j++) win_cells[i][j] = win_cells[i][j + 1];
            win_cells[i][SPAN - 1] = fresh[i];
        end

        // interior centre inside the current image size
        if (row_pos >= LINES && c >= LINES && row_pos < nrows && c < ncols) begin
            centre = win_cells[WIN_RADIUS][WIN_RADIUS];
            if (centre[HEIGHT_W] && centre[HEIGHT_W-1:0] >= sw_cfg.peak_floor) begin
                limit = {1'b0, centre[HEIGHT_W-1:0]} + {1'b0, sw_cfg.rise_margin};
                hit = 1'b1;
                for (int i = 0; i < SPAN; i++)
                    for (int j = 0; j < SPAN; j++)
                        if (!(i == WIN_RADIUS && j == WIN_RADIUS) &&
                            {1'b0, win_cells[i][j][HEIGHT_W-1:0]} > limit)
                            hit = 1'b0;
                pk.row    = OUT_ROW_W'(row_pos - WIN_RADIUS);
                pk.col    = OUT_COL_W'(c - WIN_RADIUS);
                pk.height = centre[HEIGHT_W-1:0];
            end
        end

        // raster position, wrapping at the current size
        if (col_pos + 1 >= ncols) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= nrows) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic void fill_pixel(input fill_e fill, input logic [HEIGHT_W-1:0] base,
                                       output logic [HEIGHT_W-1:0] h, output logic occ);
        int unsigned pick;
        pick = $urandom_range(0, 31);
        case (fill)
            FILL_HILLS: begin
                h = base + HEIGHT_W'($urandom_range(0, 'h1FF));
                if (pick == 0) h = '1;
                if (pick == 1) h = '0;
                occ = ($urandom_range(0, 7) != 0);
            end
            FILL_TOPS: begin
                h = '1 - HEIGHT_W'($urandom_range(0, 3));
                occ = ($urandom_range(0, 3) != 0);
            end
            default: begin
                h = HEIGHT_W'($urandom);
                occ = 1'($urandom_range(0, 1));
            end
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 0;
        if (pick < 9) return $urandom_range(1, 4);
        return $urandom_range(5, 20);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return CFG_DATA_W'($urandom_range(0, 'h300));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_PEAK_FLOOR:  sw_cfg.peak_floor = data;
            CFG_RISE_MARGIN: sw_cfg.rise_margin = data;
            CFG_IMAGE_COLS:  sw_cfg.cols = data[SIZE_W-1:0];
            CFG_IMAGE_ROWS:  sw_cfg.rows = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // stop offering, wait for every peak and for beats still in flight
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (peaks_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one pixel beat in bursts with random gaps, predicted once accepted
    task automatic send_pixel(input logic [HEIGHT_W-1:0] h, input logic occ,
                              input bit typed, input bit typed_hit, input peak_t typed_pk);
        int unsigned gap;
        bit          hit;
        peak_t       pk;
        if (burst_left == 0) begin
            gap = pick_gap();
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_height <= h;
        s_occupied <= occ;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        scan_pixel(h, occ, hit, pk);
        if (typed) begin
            hit = typed_hit;
            pk = typed_pk;
        end
        if (hit) peaks_due = {peaks_due, pk};
    endtask

    task automatic run_phase(input phase_t p);
        logic [HEIGHT_W-1:0] base;
        logic [HEIGHT_W-1:0] h;
        logic                occ;
        settle();
        write_reg(CFG_PEAK_FLOOR, p.min_h);
        write_reg(CFG_RISE_MARGIN, p.thr);
        write_reg(CFG_IMAGE_COLS, p.cols);
        write_reg(CFG_IMAGE_ROWS, p.rows);
        if (p.stall) hold_asks <= hold_asks + 1;
        base = HEIGHT_W'($urandom_range(0, 'hFD00));
        // an explicit count may stop mid-frame, otherwise whole frames
        if (p.n_pix > 0) begin
            repeat (p.n_pix) begin
                fill_pixel(p.fill, base, h, occ);
                send_pixel(h, occ, 1'b0, 1'b0, '0);
            end
        end else begin
            for (int f = 0; f < p.frames; f++) begin
                do begin
                    fill_pixel(p.fill, base, h, occ);
                    send_pixel(h, occ, 1'b0, 1'b0, '0);
                end while (row_pos != 0 || col_pos != 0);
            end
        end
    endtask

    // result side: stall pattern selected by rx_cycle[9:7], plus long holds
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (rx_cycle[9:7])
                3'd2:    m_ready <= 1'($urandom_range(0, 1));
                3'd3:    m_ready <= (rx_cycle[1:0] == 2'd0);
                3'd4:    m_ready <= ($urandom_range(0, 3) != 0);
                3'd5:    m_ready <= ~rx_cycle[3];
                3'd6:    m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    // compare each peak beat with the oldest one due
    always @(posedge aclk) begin
        peak_t want;
        if (aresetn && m_valid && m_ready) begin
            if (peaks_due.size() == 0) begin
                report_mismatch("unexpected peak beat, height", int'(m_peak_height), 0);
            end else begin
                want = peaks_due.pop_front();
                if (m_peak_row !== want.row)
                    report_mismatch("peak_row", int'(m_peak_row), int'(want.row));
                if (m_peak_col !== want.col)
                    report_mismatch("peak_col", int'(m_peak_col), int'(want.col));
                if (m_peak_height !== want.height)
                    report_mismatch("peak_height", int'(m_peak_height),
                                    int'(want.height));
            end
        end
    end

    initial begin
        #(WATCHDOG_CYCLES * 2 * CLK_HALF);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        phase_t p;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_steps[i]) begin
            if (dir_steps[i].is_cfg) begin
                settle();
                write_reg(dir_steps[i].idx, dir_steps[i].data);
            end else begin
                for (int n = 0; n < dir_steps[i].reps; n++)
                    send_pixel(dir_steps[i].h, dir_steps[i].occ, 1'b1,
                               dir_steps[i].hit && n == dir_steps[i].reps - 1,
                               dir_steps[i].pk);
            end
        end

        foreach (fixed_phases[i]) run_phase(fixed_phases[i]);

        // random single-frame phases
        for (int i = 0; i < RANDOM_PHASES; i++) begin
            p.min_h  = pick_level();
            p.thr    = pick_level();
            p.cols   = CFG_DATA_W'($urandom_range(5, 10));
            p.rows   = CFG_DATA_W'($urandom_range(5, 6));
            p.frames = 1;
            p.n_pix  = 0;
            p.fill   = fill_e'($urandom_range(0, 2));
            p.stall  = 1'b0;
            run_phase(p);
        end

        // drain
        s_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && peaks_due.size() != 0; n++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (peaks_due.size() != 0)
            report_mismatch("peak beats never delivered", 0, peaks_due.size());

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
